// ===== rtl/mbp_pkg.sv =====
// mbp_pkg: shared types and constants for the msb-first bit packer
// no dependencies; imported by every module under rtl

package mbp_pkg;

    // byte geometry
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int FILL_W  = 3;

    // full-byte bit count
    localparam logic [COUNT_W-1:0] FULL_BITS = 4'd8;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one input transaction
    typedef struct packed {
        logic [BYTE_W-1:0]  data_bits;
        logic [COUNT_W-1:0] num_bits;
        logic               right_aligned;
        logic               flush;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] out_bits;
        logic               last;
    } result_t;

    // up to two results produced by one item, in order
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

// ===== rtl/msb_first_bit_packer_top.sv =====
// msb_first_bit_packer_top: input register, packer and result queue
// depends on mbp_pkg, mbp_pack, mbp_out_queue
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready  | data_bits, num_bits, right_aligned, flush
//   output  | out       | out_valid / out_ready| out_byte, out_bits, last
//
// one input transaction a cycle while the queue has room for two results; each
// passes the input register, then the result queue, before its earliest result
// an item with two results occupies the output port for each result in turn,
// so the output port sets the sustained rate of results delivered
// reset clears the packing state, the input register's valid flag and the queue
// input stalls when the input register is held and the queue has fewer than two free slots

module msb_first_bit_packer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_bits,
    input  logic [3:0] num_bits,
    input  logic       right_aligned,
    input  logic       flush,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [3:0] out_bits,
    output logic       last
);
    import mbp_pkg::*;

    logic    item_valid_reg, item_valid_next;
    item_t   item_reg;
    logic    room;
    logic    advance;
    push_t   push;
    result_t head;

    // input register moves on when the queue can take two results
    assign advance  = item_valid_reg && room;
    assign in_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data_bits     <= data_bits;
            item_reg.num_bits      <= num_bits;
            item_reg.right_aligned <= right_aligned;
            item_reg.flush         <= flush;
        end
    end

    // packing logic
    mbp_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .push    (push)
    );

    // result queue
    mbp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte = head.out_byte;
    assign out_bits = head.out_bits;
    assign last     = head.last;

endmodule

// ===== rtl/mbp_pack.sv =====
// mbp_pack: packing logic and the partial byte / fill count state
// depends on mbp_pkg

module mbp_pack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  mbp_pkg::item_t item,
    output mbp_pkg::push_t push
);
    import mbp_pkg::*;

    logic [BYTE_W-1:0]  partial_reg, partial_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic [COUNT_W-1:0] n;
    logic [15:0]        top_mask;
    logic [15:0]        shifted_src;
    logic [15:0]        spill;
    logic [BYTE_W-1:0]  v;
    logic [BYTE_W-1:0]  merged;
    logic [COUNT_W-1:0] total;
    logic [BYTE_W-1:0]  mid_partial;
    logic [FILL_W-1:0]  mid_fill;
    logic               full_out;

    // saturate count and line up the valid bits at the top
    always_comb
    begin
        n           = (item.num_bits > FULL_BITS) ? FULL_BITS : item.num_bits;
        top_mask    = 16'hFF00 >> n;
        shifted_src = {8'd0, item.data_bits} << (FULL_BITS - n);
        if ((n < FULL_BITS) && item.right_aligned)
        begin
            v = shifted_src[7:0];
        end
        else
        begin
            v = item.data_bits & top_mask[7:0];
        end
    end

    // append to the held bits, split off a completed byte
    always_comb
    begin
        merged      = partial_reg | (v >> fill_reg);
        total       = {1'b0, fill_reg} + n;
        spill       = {8'd0, v} << (FULL_BITS - {1'b0, fill_reg});
        full_out    = 1'b0;
        mid_partial = partial_reg;
        mid_fill    = fill_reg;
        if (n != '0)
        begin
            if (total >= FULL_BITS)
            begin
                full_out    = 1'b1;
                mid_partial = spill[7:0];
                mid_fill    = FILL_W'(total - FULL_BITS);
            end
            else
            begin
                mid_partial = merged;
                mid_fill    = total[FILL_W-1:0];
            end
        end
    end

    // results and next state, flush emits the padded partial byte
    always_comb
    begin
        push               = '0;
        push.res0.out_byte = merged;
        push.res0.out_bits = FULL_BITS;
        push.res1.out_byte = mid_partial;
        push.res1.out_bits = {1'b0, mid_fill};
        partial_next       = partial_reg;
        fill_next          = fill_reg;
        if (advance)
        begin
            partial_next = mid_partial;
            fill_next    = mid_fill;
            if (item.flush && (mid_fill != '0))
            begin
                partial_next = '0;
                fill_next    = '0;
                if (full_out)
                begin
                    push.valid0    = 1'b1;
                    push.valid1    = 1'b1;
                    push.res1.last = 1'b1;
                end
                else
                begin
                    // partial byte alone goes in the first slot
                    push.valid0    = 1'b1;
                    push.res0      = push.res1;
                    push.res0.last = 1'b1;
                end
            end
            else if (full_out)
            begin
                push.valid0    = 1'b1;
                push.res0.last = 1'b1;
            end
        end
    end

    // packing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
        end
    end

    // a second result only follows a first one
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0)
        else $error("second result without first");

    // with two results, the first is a full byte and only the second is last
    a_two_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> (push.res0.out_bits == FULL_BITS) && !push.res0.last
                        && push.res1.last)
        else $error("bad ordering of two results");

    // a flush item leaves nothing held
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.flush) |=> (fill_reg == '0) && (partial_reg == '0))
        else $error("flush left bits held");

endmodule

// ===== rtl/mbp_out_queue.sv =====
// mbp_out_queue: small result queue, takes up to two results, gives one
// depends on mbp_pkg

module mbp_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  mbp_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output mbp_pkg::result_t head
);
    import mbp_pkg::*;

    result_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;
    logic [1:0]         n_push;

    // status and head of the queue
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push.valid0} + {1'b0, push.valid1};

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, two write slots
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
        end
    end

    // never more entries than slots
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue overflow");

    // pushes only arrive with room for two
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid0 |-> room)
        else $error("push without room");

    // count tracks pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + QCNT_W'($past(n_push))
                              - QCNT_W'($past(pop)))
        else $error("queue count mismatch");

endmodule
